### rtl/lirs_pkg.sv
// Types and field widths shared by the linear index region statistics block.
package lirs_pkg;

    localparam int IDX_W      = 25;
    localparam int CFG_W      = 13;
    localparam int ROW_W      = 13;
    localparam int COL_W      = 25;
    localparam int MEAN_ROW_W = 21;
    localparam int MEAN_COL_W = 33;

    typedef struct packed {
        logic [IDX_W-1:0] linear_index;
        logic             last_index;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      column;
        logic                  summary_valid;
        logic [ROW_W-1:0]      min_row;
        logic [ROW_W-1:0]      max_row;
        logic [MEAN_ROW_W-1:0] mean_row;
        logic [COL_W-1:0]      min_column;
        logic [COL_W-1:0]      max_column;
        logic [MEAN_COL_W-1:0] mean_column;
    } t_out_item;

endpackage

### rtl/linear_index_region_stats.sv
// Top level: splits linear pixel indices into row and column and keeps region statistics.
// An item is taken only while idle, so no new item is taken until the last one's result is registered;
// a radix-2 divider sharing one subtractor takes one quotient bit a cycle.
// An item marked last runs the same divider twice more for the means.
// Synchronous active-low reset sets the height register to 1 and clears the region state.
module linear_index_region_stats
    import lirs_pkg::*;
#(
    parameter int MAX_HEIGHT       = 4096,
    parameter int MAX_REGION_COUNT = 16777216,
    parameter int MEAN_FRAC_BITS   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_REGION_COUNT + 1);
    localparam int RTW = HW + CW;
    localparam int CTW = COL_W + CW;
    localparam int VW  = (HW > CW) ? HW : CW;
    localparam int DW  = (CTW + MEAN_FRAC_BITS > IDX_W) ? CTW + MEAN_FRAC_BITS : IDX_W;
    localparam int SW  = $clog2(DW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_IDX,
        S_UPDATE,
        S_DIV_ROW,
        S_DIV_COL,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [CFG_W-1:0]      r_height;
    logic                  r_last;
    logic [VW-1:0]         r_divisor;
    logic [VW-1:0]         r_rem;
    logic [DW-1:0]         r_dividend;
    logic [SW-1:0]         r_steps;
    logic [HW-1:0]         r_row;
    logic [COL_W-1:0]      r_col;
    logic [MEAN_ROW_W-1:0] r_mean_row;
    logic [CW-1:0]         r_count;
    logic [HW-1:0]         r_row_lo;
    logic [HW-1:0]         r_row_hi;
    logic [RTW-1:0]        r_row_sum;
    logic [COL_W-1:0]      r_col_lo;
    logic [COL_W-1:0]      r_col_hi;
    logic [CTW-1:0]        r_col_sum;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [VW:0]      trial;
    logic             qbit;
    logic [VW:0]      diff;
    logic [VW-1:0]    step_rem;
    logic [DW-1:0]    step_div;
    logic [IDX_W-1:0] zero_based;
    logic [31:0]      h_wide;
    logic [VW-1:0]    h_eff;
    logic [HW-1:0]    cur_row;
    logic [COL_W-1:0] cur_col;
    logic             first;
    logic             room;
    logic [CW-1:0]    n_count;
    logic [HW-1:0]    n_row_lo;
    logic [HW-1:0]    n_row_hi;
    logic [RTW-1:0]   n_row_sum;
    logic [COL_W-1:0] n_col_lo;
    logic [COL_W-1:0] n_col_hi;
    logic [CTW-1:0]   n_col_sum;
    logic             out_free;

    always_comb begin
        trial    = {r_rem, r_dividend[DW-1]};
        qbit     = trial >= {1'b0, r_divisor};
        diff     = trial - {1'b0, r_divisor};
        step_rem = qbit ? diff[VW-1:0] : trial[VW-1:0];
        step_div = {r_dividend[DW-2:0], qbit};
    end

    always_comb begin
        zero_based = (i_in_item.linear_index == '0) ? '0
                                                     : i_in_item.linear_index - IDX_W'(1);
        h_wide = 32'(r_height);
        if (h_wide == 32'd0) begin
            h_wide = 32'd1;
        end else if (h_wide > 32'(MAX_HEIGHT)) begin
            h_wide = 32'(MAX_HEIGHT);
        end
        h_eff = h_wide[VW-1:0];
    end

    always_comb begin
        cur_row   = HW'(r_rem) + HW'(1);
        cur_col   = COL_W'(r_dividend) + COL_W'(1);
        first     = r_count == '0;
        room      = r_count < CW'(MAX_REGION_COUNT);
        n_row_lo  = (first || cur_row < r_row_lo) ? cur_row : r_row_lo;
        n_row_hi  = (first || cur_row > r_row_hi) ? cur_row : r_row_hi;
        n_col_lo  = (first || cur_col < r_col_lo) ? cur_col : r_col_lo;
        n_col_hi  = (first || cur_col > r_col_hi) ? cur_col : r_col_hi;
        n_count   = room ? r_count + CW'(1) : r_count;
        n_row_sum = room ? r_row_sum + RTW'(cur_row) : r_row_sum;
        n_col_sum = room ? r_col_sum + CTW'(cur_col) : r_col_sum;
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_height    <= CFG_W'(1);
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_row_lo    <= '0;
            r_row_hi    <= '0;
            r_row_sum   <= '0;
            r_col_lo    <= '0;
            r_col_hi    <= '0;
            r_col_sum   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_height <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last     <= i_in_item.last_index;
                        r_divisor  <= h_eff;
                        r_rem      <= '0;
                        r_dividend <= DW'(zero_based) << (DW - IDX_W);
                        r_steps    <= SW'(IDX_W);
                        r_state    <= S_DIV_IDX;
                    end
                end
                S_DIV_IDX: begin
                    r_rem      <= step_rem;
                    r_dividend <= step_div;
                    r_steps    <= r_steps - SW'(1);
                    if (r_steps == SW'(1)) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_row     <= cur_row;
                    r_col     <= cur_col;
                    r_count   <= n_count;
                    r_row_lo  <= n_row_lo;
                    r_row_hi  <= n_row_hi;
                    r_row_sum <= n_row_sum;
                    r_col_lo  <= n_col_lo;
                    r_col_hi  <= n_col_hi;
                    r_col_sum <= n_col_sum;
                    if (r_last) begin
                        r_divisor  <= VW'(n_count);
                        r_rem      <= '0;
                        r_dividend <= DW'(n_row_sum) << (DW - RTW);
                        r_steps    <= SW'(RTW + MEAN_FRAC_BITS);
                        r_state    <= S_DIV_ROW;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_DIV_ROW: begin
                    r_rem      <= step_rem;
                    r_dividend <= step_div;
                    r_steps    <= r_steps - SW'(1);
                    if (r_steps == SW'(1)) begin
                        r_mean_row <= MEAN_ROW_W'(step_div);
                        r_rem      <= '0;
                        r_dividend <= DW'(r_col_sum) << (DW - CTW);
                        r_steps    <= SW'(CTW + MEAN_FRAC_BITS);
                        r_state    <= S_DIV_COL;
                    end
                end
                S_DIV_COL: begin
                    r_rem      <= step_rem;
                    r_dividend <= step_div;
                    r_steps    <= r_steps - SW'(1);
                    if (r_steps == SW'(1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out.row           <= ROW_W'(r_row);
                        r_out.column        <= r_col;
                        r_out.summary_valid <= r_last;
                        if (r_last) begin
                            r_out.min_row     <= ROW_W'(r_row_lo);
                            r_out.max_row     <= ROW_W'(r_row_hi);
                            r_out.mean_row    <= r_mean_row;
                            r_out.min_column  <= r_col_lo;
                            r_out.max_column  <= r_col_hi;
                            r_out.mean_column <= MEAN_COL_W'(r_dividend);
                            r_count           <= '0;
                            r_row_lo          <= '0;
                            r_row_hi          <= '0;
                            r_row_sum         <= '0;
                            r_col_lo          <= '0;
                            r_col_hi          <= '0;
                            r_col_sum         <= '0;
                        end else begin
                            r_out.min_row     <= '0;
                            r_out.max_row     <= '0;
                            r_out.mean_row    <= '0;
                            r_out.min_column  <= '0;
                            r_out.max_column  <= '0;
                            r_out.mean_column <= '0;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/lirs_checker.sv
// Port-level checker for the region statistics block and its bind to the top level.
module lirs_checker
    import lirs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CFG_W-1:0] i_cfg_data,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input t_in_item         i_in_item,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_item        o_out_item
);

    // A transfer on the input starts a division, during which the input is not ready.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after a transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.row != '0 && o_out_item.column != '0)
        else $error("row or column is zero");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.summary_valid |->
            o_out_item.min_row == '0 && o_out_item.max_row == '0 &&
            o_out_item.mean_row == '0 && o_out_item.min_column == '0 &&
            o_out_item.max_column == '0 && o_out_item.mean_column == '0)
        else $error("summary fields set on an ordinary result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.summary_valid |->
            o_out_item.min_row <= o_out_item.max_row &&
            o_out_item.min_column <= o_out_item.max_column)
        else $error("bounding box minimum above maximum");

endmodule

bind linear_index_region_stats lirs_checker u_lirs_checker (.*);
